@@ rtl/core/jsu_pkg.sv @@
package jsu_pkg;

    localparam int unsigned MAX_STRING_BYTES_DEF = 65535;
    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
    localparam int unsigned PEND_DEPTH = 11;
    localparam int unsigned PEND_IW = 4;

    // decoder phases
    localparam logic [3:0] PH_PLAIN = 4'd0;
    localparam logic [3:0] PH_ESC   = 4'd1;
    localparam logic [3:0] PH_HEX0  = 4'd2;
    localparam logic [3:0] PH_HEX3  = 4'd5;
    localparam logic [3:0] PH_LOWBS = 4'd6;
    localparam logic [3:0] PH_LOWU  = 4'd7;
    localparam logic [3:0] PH_LHEX0 = 4'd8;
    localparam logic [3:0] PH_LHEX3 = 4'd11;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
        logic [15:0] total_length;
        logic       truncated;
    } t_result;

    // command from controller to datapath
    typedef struct packed {
        logic       load;       // take a new input byte into the source slot
        logic       step;       // decode the current source byte
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic       busy;       // replay bytes or pending code bytes remain
        logic       out_full;   // result register holds an untaken result
    } t_stat;

endpackage

@@ rtl/core/jsu_if.sv @@
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_end;
    logic [15:0] total_length;
    logic        truncated;
    modport source (output valid, output out_byte, output is_end, output total_length,
                    output truncated, input ready);
    modport sink   (input valid, input out_byte, input is_end, input total_length,
                    input truncated, output ready);
endinterface

interface jsu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/json_string_unescape_utf8.sv @@
// Channel  | Dir | Payload
// in_ch    | in  | in_byte
// out_ch   | out | out_byte, is_end, total_length, truncated
// cfg_ch   | in  | output_limit
// Each input byte is first accepted and then decoded; a code point's UTF-8
// bytes after its first are held in a queue and emitted in turn.
// A malformed escape emits a backslash and then replays its held characters.
// Decoding stalls while the result register holds an untaken result.
// A new byte is taken only after the previous byte is fully decoded.
// Reset clears decoder state and sets output_limit to 65535.
module json_string_unescape_utf8 #(
    parameter int unsigned MAX_STRING_BYTES = jsu_pkg::MAX_STRING_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    jsu_in_if.sink   in_ch,
    jsu_out_if.source out_ch,
    jsu_cfg_if.sink  cfg_ch
);
    jsu_pkg::t_cmd cmd;
    jsu_pkg::t_stat stat;
    jsu_pkg::t_result res;
    logic in_ready;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready = in_ready;

    jsu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .o_in_ready(in_ready), .i_stat(stat), .o_cmd(cmd)
    );

    jsu_dp #(.MAX_STRING_BYTES(MAX_STRING_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_in_byte(in_ch.in_byte), .i_cfg_we(cfg_ch.valid), .i_cfg_data(cfg_ch.data),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .o_out(res)
    );

    assign out_ch.out_byte = res.out_byte;
    assign out_ch.is_end = res.is_end;
    assign out_ch.total_length = res.total_length;
    assign out_ch.truncated = res.truncated;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ready |=> !in_ready)
        else $error("accepted while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result lost");
`endif
endmodule

@@ rtl/core/jsu_ctrl.sv @@
module jsu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  jsu_pkg::t_stat i_stat,
    output jsu_pkg::t_cmd  o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_WORK = 1'b1;

    logic r_state, n_state;

    // accept when nothing remains to decode
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.load = o_in_ready && i_in_valid;
        o_cmd.step = (r_state == S_WORK) && !i_stat.out_full;
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_WORK;
            S_WORK: if (o_cmd.step && !i_stat.busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

@@ rtl/core/jsu_dp.sv @@
module jsu_dp #(
    parameter int unsigned MAX_STRING_BYTES = jsu_pkg::MAX_STRING_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jsu_pkg::t_cmd   i_cmd,
    output jsu_pkg::t_stat  o_stat,
    input  logic [7:0]      i_in_byte,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output jsu_pkg::t_result o_out
);
    localparam logic [15:0] COUNT_CAP =
        (MAX_STRING_BYTES > 65535) ? 16'hFFFF : 16'(MAX_STRING_BYTES);
    localparam int QD = 2 * jsu_pkg::PEND_DEPTH + 2;

    logic [15:0] r_limit;
    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_pend [jsu_pkg::PEND_DEPTH];
    logic [3:0]  r_pcnt, n_pcnt;
    logic [9:0]  r_hs, n_hs;
    logic [15:0] r_hex, n_hex;
    logic [15:0] r_cnt, n_cnt;
    logic        r_sat, n_sat;
    // replay queue of raw characters
    logic [7:0]  r_q [QD];
    logic [4:0]  r_qn, n_qn;
    // code bytes waiting to be emitted, up to three
    logic [7:0]  r_cb [4];
    logic [2:0]  r_cbn, n_cbn;
    logic [7:0]  n_cb [4];
    logic [7:0]  n_q [QD];
    logic        r_ov;
    jsu_pkg::t_result r_out;

    logic        emit_v, end_v, bad, pend_wr;
    logic [7:0]  emit_b, c;
    logic [15:0] cap;
    logic [3:0]  d;
    logic        d_ok;
    logic [15:0] h;
    logic [20:0] cp;
    logic        cp_v;
    logic        data_set;

    assign cap = (r_limit == 16'd0) ? 16'd0 : r_limit - 16'd1;
    assign c = r_q[0];

    always_comb begin
        d_ok = 1'b1; d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
        else d_ok = 1'b0;
    end

    // decode one byte per step: emit code bytes first, then a queued char
    always_comb begin
        n_phase = r_phase; n_pcnt = r_pcnt; n_hs = r_hs; n_hex = r_hex;
        n_cnt = r_cnt; n_sat = r_sat; n_qn = r_qn; n_cbn = r_cbn;
        n_cb = r_cb; n_q = r_q;
        emit_v = 1'b0; emit_b = 8'd0; end_v = 1'b0; bad = 1'b0; pend_wr = 1'b0;
        h = {r_hex[11:0], d}; cp = '0; cp_v = 1'b0;
        if (r_cbn != 3'd0) begin
            emit_v = 1'b1; emit_b = r_cb[0];
            n_cb[0] = r_cb[1]; n_cb[1] = r_cb[2]; n_cb[2] = r_cb[3];
            n_cbn = r_cbn - 3'd1;
        end else if (r_qn != 5'd0) begin
            for (int i = 0; i < QD - 1; i++) n_q[i] = r_q[i + 1];
            n_qn = r_qn - 5'd1;
            if (r_phase == jsu_pkg::PH_PLAIN) begin
                if (c == 8'h00 || c == 8'h22) begin
                    end_v = 1'b1; n_qn = 5'd0;
                    n_cnt = 16'd0; n_sat = 1'b0; n_hs = '0; n_hex = '0; n_pcnt = '0;
                end else if (c == 8'h5C) begin
                    n_phase = jsu_pkg::PH_ESC; n_pcnt = '0;
                end else begin
                    emit_v = 1'b1; emit_b = c;
                end
            end else begin
                pend_wr = (r_pcnt < 4'(jsu_pkg::PEND_DEPTH));
                if (pend_wr) n_pcnt = r_pcnt + 4'd1;
                case (r_phase)
                    jsu_pkg::PH_ESC: begin
                        n_phase = jsu_pkg::PH_PLAIN; n_pcnt = '0;
                        case (c)
                            8'h22, 8'h5C, 8'h2F: begin emit_v = 1'b1; emit_b = c; end
                            8'h62: begin emit_v = 1'b1; emit_b = 8'h08; end
                            8'h66: begin emit_v = 1'b1; emit_b = 8'h0C; end
                            8'h6E: begin emit_v = 1'b1; emit_b = 8'h0A; end
                            8'h72: begin emit_v = 1'b1; emit_b = 8'h0D; end
                            8'h74: begin emit_v = 1'b1; emit_b = 8'h09; end
                            8'h75: begin
                                n_phase = jsu_pkg::PH_HEX0; n_hex = '0;
                                n_pcnt = r_pcnt + 4'd1;
                            end
                            default: bad = 1'b1;
                        endcase
                    end
                    jsu_pkg::PH_LOWBS: begin
                        if (c != 8'h5C) bad = 1'b1;
                        else n_phase = jsu_pkg::PH_LOWU;
                    end
                    jsu_pkg::PH_LOWU: begin
                        if (c != 8'h75) bad = 1'b1;
                        else begin n_phase = jsu_pkg::PH_LHEX0; n_hex = '0; end
                    end
                    default: begin
                        if (r_phase > jsu_pkg::PH_LHEX3 || !d_ok) bad = 1'b1;
                        else begin
                            n_hex = h;
                            if (r_phase != jsu_pkg::PH_HEX3 && r_phase != jsu_pkg::PH_LHEX3)
                                n_phase = r_phase + 4'd1;
                            else if (r_phase == jsu_pkg::PH_HEX3) begin
                                if (h == 16'd0 || (h >= 16'hDC00 && h <= 16'hDFFF)) bad = 1'b1;
                                else if (h >= 16'hD800 && h <= 16'hDBFF) begin
                                    n_hs = 10'(h - 16'hD800); n_phase = jsu_pkg::PH_LOWBS;
                                end else begin
                                    cp = {5'd0, h}; cp_v = 1'b1;
                                end
                            end else begin
                                if (h < 16'hDC00 || h > 16'hDFFF) bad = 1'b1;
                                else begin
                                    cp = {1'b0, r_hs, h[9:0]} + 21'h10000; cp_v = 1'b1;
                                end
                            end
                        end
                    end
                endcase
                if (cp_v) begin
                    n_phase = jsu_pkg::PH_PLAIN; n_pcnt = '0;
                    if (cp < 21'h80) begin
                        emit_v = 1'b1; emit_b = cp[7:0];
                    end else if (cp < 21'h800) begin
                        emit_v = 1'b1; emit_b = 8'hC0 | 8'(cp[10:6]);
                        n_cb[0] = 8'h80 | 8'(cp[5:0]); n_cbn = 3'd1;
                    end else if (cp < 21'h10000) begin
                        emit_v = 1'b1; emit_b = 8'hE0 | 8'(cp[15:12]);
                        n_cb[0] = 8'h80 | 8'(cp[11:6]);
                        n_cb[1] = 8'h80 | 8'(cp[5:0]); n_cbn = 3'd2;
                    end else begin
                        emit_v = 1'b1; emit_b = 8'hF0 | 8'(cp[20:18]);
                        n_cb[0] = 8'h80 | 8'(cp[17:12]);
                        n_cb[1] = 8'h80 | 8'(cp[11:6]);
                        n_cb[2] = 8'h80 | 8'(cp[5:0]); n_cbn = 3'd3;
                    end
                end
                // malformed: emit backslash, replay pending chars plus rest
                if (bad) begin
                    emit_v = 1'b1; emit_b = 8'h5C;
                    n_phase = jsu_pkg::PH_PLAIN; n_pcnt = '0;
                    for (int i = 0; i < QD; i++) begin
                        if (i < int'(r_pcnt)) n_q[i] = r_pend[i];
                        else if (i == int'(r_pcnt)) n_q[i] = c;
                        else if (i - int'(r_pcnt) < QD) n_q[i] = r_q[i - int'(r_pcnt)];
                    end
                    n_qn = 5'(int'(r_qn) + int'(r_pcnt));
                    if (!pend_wr) n_qn = 5'(int'(r_qn) - 1 + int'(r_pcnt));
                    if (!pend_wr)
                        for (int i = 0; i < QD - 1; i++)
                            if (i >= int'(r_pcnt)) n_q[i] = r_q[i - int'(r_pcnt) + 1];
                end
            end
        end
        // count and saturate
        if (emit_v && !r_sat) begin
            if (r_cnt >= COUNT_CAP) n_sat = 1'b1;
            else n_cnt = r_cnt + 16'd1;
        end
    end

    // load the result register on an end or on an emitted data byte within the limit
    assign data_set = emit_v && !r_sat && r_cnt < COUNT_CAP && r_cnt < cap;

    assign o_stat.out_full = r_ov && !i_out_ready;
    assign o_stat.busy = (n_cbn != 3'd0) || (n_qn != 5'd0);
    assign o_out_valid = r_ov;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= jsu_pkg::LIMIT_RESET;
            r_phase <= jsu_pkg::PH_PLAIN; r_pcnt <= '0; r_hs <= '0; r_hex <= '0;
            r_cnt <= '0; r_sat <= 1'b0; r_qn <= '0; r_cbn <= '0; r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            r_ov <= (r_ov && !i_out_ready) || (i_cmd.step && (end_v || data_set));
            if (i_cmd.load) begin
                r_q[0] <= i_in_byte; r_qn <= 5'd1;
            end
            if (i_cmd.step) begin
                r_phase <= n_phase; r_pcnt <= n_pcnt; r_hs <= n_hs; r_hex <= n_hex;
                r_cnt <= n_cnt; r_sat <= n_sat; r_qn <= n_qn; r_cbn <= n_cbn;
                r_cb <= n_cb; r_q <= n_q;
                if (pend_wr) r_pend[r_pcnt] <= c;
                if (end_v) begin
                    r_out <= '{8'd0, 1'b1, r_cnt, r_sat || (r_cnt > cap)};
                end else if (data_set) begin
                    r_out <= '{emit_b, 1'b0, 16'd0, 1'b0};
                end
            end
        end
    end
endmodule
